/* sv/iefa_pkg.sv */
// ---------------------------------------------------------------------------
// iefa_pkg
// Shared types and constants for the input event filter with autorepeat.
// ---------------------------------------------------------------------------
package iefa_pkg;

    localparam int KEY_COUNT  = 768;
    localparam int AXIS_COUNT = 64;
    localparam int MAX_SLOTS  = 16;
    localparam int SLOT_AXES  = 14;

    localparam int KEY_W   = $clog2(KEY_COUNT);
    localparam int AXIS_W  = $clog2(AXIS_COUNT);
    localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SAX_W   = (SLOT_AXES > 1) ? $clog2(SLOT_AXES) : 1;
    localparam int SDEP    = MAX_SLOTS * SLOT_AXES;
    localparam int SDEP_W  = $clog2(SDEP);

    // Length of the clearing pass after reset: the deepest table.
    localparam int CLR_N   = (KEY_COUNT > SDEP) ? KEY_COUNT : SDEP;
    localparam int CLR_W   = $clog2(CLR_N + 1);

    localparam logic [9:0] SLOT_CODE = 10'd47;
    localparam logic [9:0] MT_FIRST  = 10'd48;

    localparam logic [4:0] TYPE_SYN  = 5'd0;
    localparam logic [4:0] TYPE_KEY  = 5'd1;
    localparam logic [4:0] TYPE_REL  = 5'd2;
    localparam logic [4:0] TYPE_ABS  = 5'd3;
    localparam logic [4:0] TYPE_MISC = 5'd4;

    localparam logic [15:0] DELAY_RST  = 16'd250;
    localparam logic [15:0] PERIOD_RST = 16'd33;

    typedef enum logic [1:0] {
        OP_EVENT = 2'd0,
        OP_TICK  = 2'd1,
        OP_FUZZ  = 2'd2,
        OP_CAP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_EN     = 2'd0,
        REG_DELAY  = 2'd1,
        REG_PERIOD = 2'd2,
        REG_SLOTS  = 2'd3
    } t_reg;

    // Classified word handed from the front to the back.
    typedef struct packed {
        t_op         op;
        logic [4:0]  ev_type;
        logic [9:0]  ev_code;
        logic [31:0] ev_value;
    } t_cmd;

    // One emitted word.
    typedef struct packed {
        logic [4:0]  typ;
        logic [9:0]  code;
        logic [31:0] value;
        logic        last;
    } t_res;

    function automatic logic [31:0] defuzz(logic signed [31:0] v,
                                           logic signed [31:0] o,
                                           logic signed [31:0] f);
        logic signed [35:0] vv, oo, ff, h, s3, s2;
        logic [31:0] r;
        begin
            vv = 36'(v); oo = 36'(o); ff = 36'(f);
            h  = (ff < 0) ? -((-ff) >>> 1) : (ff >>> 1);
            s3 = oo * 3 + vv;
            s2 = oo + vv;
            r  = v;
            if (f != 0) begin
                if (vv > oo - h && vv < oo + h) begin
                    r = o;
                end else if (vv > oo - ff && vv < oo + ff) begin
                    r = 32'((s3 < 0) ? -((-s3) >>> 2) : (s3 >>> 2));
                end else if (vv > oo - 2 * ff && vv < oo + 2 * ff) begin
                    r = 32'((s2 < 0) ? -((-s2) >>> 1) : (s2 >>> 1));
                end
            end
            return r;
        end
    endfunction

endpackage

/* sv/input_event_filter_autorepeat_unit.sv */
// ---------------------------------------------------------------------------
// input_event_filter_autorepeat_unit
// Event filter: abs defuzzing, slot tracking and key autorepeat.
// ---------------------------------------------------------------------------
// channel   | handshake        | words
// input     | i_push / o_full  | opcode, type, code, value
// result    | o_empty / i_pop  | type, code, value, last
// config    | APB              | enable, delay, period, slot count
// An accepted word waits in a two-word queue that parts front and back; the
// back end reads the tables as it takes the word, then updates and emits,
// and takes no new word while busy. A four-word result queue parts back and
// the consumer; the back end waits while more than two results are waiting.
// Reset is synchronous; a clearing pass then zeroes the tables, and words
// queue until it ends.
module input_event_filter_autorepeat_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_opcode,
    input  logic [4:0]  i_ev_type,
    input  logic [9:0]  i_ev_code,
    input  logic [31:0] i_ev_value,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [4:0]  o_out_type,
    output logic [9:0]  o_out_code,
    output logic [31:0] o_out_value,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import iefa_pkg::*;

    logic        r_en;
    logic [15:0] r_delay, r_period;
    logic [4:0]  r_slots;
    t_reg        ridx;

    assign pready = 1'b1;
    assign ridx   = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b1; r_delay <= DELAY_RST; r_period <= PERIOD_RST; r_slots <= '0;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            case (ridx)
                REG_EN:     r_en     <= pwdata[0];
                REG_DELAY:  r_delay  <= pwdata[15:0];
                REG_PERIOD: r_period <= pwdata[15:0];
                REG_SLOTS:  r_slots  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_EN:     prdata = {31'd0, r_en};
            REG_DELAY:  prdata = {16'd0, r_delay};
            REG_PERIOD: prdata = {16'd0, r_period};
            REG_SLOTS:  prdata = {27'd0, r_slots};
            default:    prdata = '0;
        endcase
    end

    logic   cv, ct;
    t_cmd   cmd;
    t_res   res;

    iefa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_opcode(i_opcode), .i_ev_type(i_ev_type), .i_ev_code(i_ev_code),
        .i_ev_value(i_ev_value), .o_cmd_valid(cv), .o_cmd(cmd), .i_cmd_take(ct));

    iefa_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cv), .i_cmd(cmd),
        .o_cmd_take(ct), .i_rep_en(r_en), .i_rep_delay(r_delay),
        .i_rep_period(r_period), .i_slot_count(r_slots), .o_empty(o_empty),
        .i_pop(i_pop), .o_res(res));

    assign o_out_type  = res.typ;
    assign o_out_code  = res.code;
    assign o_out_value = res.value;
    assign o_last      = res.last;
endmodule

/* sv/iefa_ram.sv */
// ---------------------------------------------------------------------------
// iefa_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module iefa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* sv/iefa_front.sv */
// ---------------------------------------------------------------------------
// iefa_front
// Accepts words, drops those that can cause nothing, queues the rest.
// ---------------------------------------------------------------------------
module iefa_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic [1:0]      i_opcode,
    input  logic [4:0]      i_ev_type,
    input  logic [9:0]      i_ev_code,
    input  logic [31:0]     i_ev_value,
    output logic            o_cmd_valid,
    output iefa_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_take
);
    import iefa_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp, n_wp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       keep, wr;
    t_cmd       c;

    always_comb begin
        c.op       = t_op'(i_opcode);
        c.ev_type  = i_ev_type;
        c.ev_code  = i_ev_code;
        c.ev_value = i_ev_value;
        keep = 1'b1;
        if (c.op == OP_EVENT) begin
            case (i_ev_type)
                TYPE_SYN:  keep = (i_ev_code <= 10'd2);
                TYPE_KEY:  keep = 1'b1;
                TYPE_REL:  keep = 1'b1;
                TYPE_ABS:  keep = 1'b1;
                TYPE_MISC: keep = 1'b1;
                default:   keep = 1'b0;
            endcase
        end
        wr    = i_push && !o_full && keep;
        n_wp  = wr ? ~r_wp : r_wp;
        n_rp  = i_cmd_take ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(wr) - 2'(i_cmd_take);
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (wr) begin
            r_q[r_wp] <= c;
        end
    end
endmodule

/* sv/iefa_back.sv */
// ---------------------------------------------------------------------------
// iefa_back
// Carries out one queued word: table reads as the word is taken, update and
// emit in the next cycle, results into a small output queue.
// ---------------------------------------------------------------------------
module iefa_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  iefa_pkg::t_cmd  i_cmd,
    output logic            o_cmd_take,
    input  logic            i_rep_en,
    input  logic [15:0]     i_rep_delay,
    input  logic [15:0]     i_rep_period,
    input  logic [4:0]      i_slot_count,
    output logic            o_empty,
    input  logic            i_pop,
    output iefa_pkg::t_res  o_res
);
    import iefa_pkg::*;

    // ---- stage 0 state -----------------------------------------------------
    logic             r_busy;
    t_cmd             r_c;
    logic [31:0]      r_pub;             // axis_value[SLOT_CODE]
    logic [SLOT_W-1:0] r_slot;
    logic [9:0]       r_rcode;
    logic             r_armed;
    logic [15:0]      r_cnt;

    // output queue, 4 deep
    t_res       r_oq [4];
    logic [1:0] r_owp, r_orp;
    logic [2:0] r_ocnt;

    // clearing pass over all tables after reset
    logic [CLR_W-1:0] r_clr;
    logic             clr_on;
    assign clr_on = (r_clr != CLR_W'(CLR_N));

    // ---- address generation on the incoming word ---------------------------
    logic [4:0]  nsl;
    logic [9:0]  ic;
    logic [SDEP_W-1:0] s_addr;
    logic [AXIS_W-1:0] a_addr;
    logic [31:0] a_rd, f_rd, s_rd;
    logic        kd_rd, kc_rd;

    assign ic    = i_cmd.ev_code;
    assign nsl   = (i_slot_count > 5'(MAX_SLOTS)) ? 5'(MAX_SLOTS) : i_slot_count;
    assign s_addr = SDEP_W'(r_slot) * SDEP_W'(SLOT_AXES) + SDEP_W'(ic - MT_FIRST);
    assign a_addr = AXIS_W'(ic);

    // a word starts when idle, the tables are clear and the output queue
    // has room for two
    logic go;
    assign go         = i_cmd_valid && !r_busy && !clr_on && (r_ocnt <= 3'd2);
    assign o_cmd_take = go;

    // ---- execute -----------------------------------------------------------
    logic        mt, st_ax, st_sl, ax_we, sl_we, fz_we, kd_we, kc_we, emit_sl;
    logic [31:0] old, fz, nv;
    logic [9:0]  c;
    logic [31:0] v;
    logic [1:0]  nres;
    t_res        e0, e1;
    logic [31:0] n_pub;
    logic [SLOT_W-1:0] n_slot;
    logic [9:0]  n_rcode;
    logic        n_armed;
    logic [15:0] n_cnt;
    logic [KEY_W-1:0] kidx, ridx;

    always_comb begin
        c     = r_c.ev_code;
        v     = r_c.ev_value;
        kidx  = KEY_W'(c);
        ridx  = KEY_W'(r_rcode);
        mt    = (c >= MT_FIRST) && (c < MT_FIRST + 10'(SLOT_AXES));
        st_ax = !mt && (c < 10'(AXIS_COUNT));
        st_sl = mt && (nsl != 5'd0);
        fz    = (c < 10'(AXIS_COUNT)) ? f_rd : 32'd0;
        old   = st_sl ? s_rd : a_rd;
        nv    = defuzz(v, old, fz);
        ax_we = 1'b0; sl_we = 1'b0; fz_we = 1'b0; emit_sl = 1'b0;
        kd_we = 1'b0; kc_we = 1'b0;
        nres  = 2'd0;
        e0    = '0; e1 = '0;
        n_pub = r_pub; n_slot = r_slot;
        n_rcode = r_rcode; n_armed = r_armed; n_cnt = r_cnt;
        if (r_busy) begin
            case (r_c.op)
                OP_FUZZ: fz_we = (c < 10'(AXIS_COUNT));
                OP_CAP:  kc_we = (c < 10'(KEY_COUNT));
                OP_TICK: begin
                    if (r_armed) begin
                        if (r_cnt > 16'd1) begin
                            n_cnt = r_cnt - 16'd1;
                        end else if (r_rcode < 10'(KEY_COUNT) && kd_rd && kc_rd) begin
                            e0 = '{TYPE_KEY, r_rcode, 32'd2, 1'b0};
                            e1 = '{TYPE_SYN, 10'd0, 32'd1, 1'b1};
                            nres = 2'd2;
                            if (i_rep_period != 16'd0) begin
                                n_cnt = i_rep_period;
                            end else begin
                                n_armed = 1'b0; n_cnt = 16'd0;
                            end
                        end else begin
                            n_armed = 1'b0; n_cnt = 16'd0;
                        end
                    end
                end
                default: begin
                    case (r_c.ev_type)
                        TYPE_KEY: begin
                            if (v != 32'd2) begin
                                kd_we = (c < 10'(KEY_COUNT));
                                if (i_rep_en) begin
                                    if (v != 32'd0) begin
                                        if (i_rep_delay != 16'd0 && i_rep_period != 16'd0) begin
                                            n_rcode = c; n_armed = 1'b1;
                                            n_cnt = i_rep_delay;
                                        end
                                    end else begin
                                        n_armed = 1'b0; n_cnt = 16'd0;
                                    end
                                end
                            end
                            e0 = '{TYPE_KEY, c, v, 1'b1}; nres = 2'd1;
                        end
                        TYPE_ABS: begin
                            if (c == SLOT_CODE) begin
                                if (nsl != 5'd0 && !v[31] && v < 32'(nsl))
                                    n_slot = SLOT_W'(v);
                            end else if ((st_ax || st_sl) && nv == old) begin
                                nres = 2'd0;
                            end else begin
                                ax_we = st_ax; sl_we = st_sl;
                                emit_sl = st_sl && (32'(r_slot) != r_pub);
                                if (emit_sl) begin
                                    n_pub = 32'(r_slot);
                                    e0 = '{TYPE_ABS, SLOT_CODE, 32'(r_slot), 1'b0};
                                    e1 = '{TYPE_ABS, c, (st_ax || st_sl) ? nv : v, 1'b1};
                                    nres = 2'd2;
                                end else begin
                                    e0 = '{TYPE_ABS, c, (st_ax || st_sl) ? nv : v, 1'b1};
                                    nres = 2'd1;
                                end
                            end
                        end
                        default: begin
                            e0 = '{r_c.ev_type, c, v, 1'b1}; nres = 2'd1;
                        end
                    endcase
                end
            endcase
        end
    end

    // The published slot lives in a register; axis RAM writes to its code
    // keep both copies in step.
    logic [31:0] pub_w;
    assign pub_w = (ax_we && c == SLOT_CODE) ? nv : n_pub;

    // write ports: zeroes from the clearing pass, else the executing word
    logic              ax_wen, fz_wen, sl_wen, kd_wen, kc_wen, kd_wd, kc_wd;
    logic [AXIS_W-1:0] ax_wa;
    logic [SDEP_W-1:0] sl_wa;
    logic [KEY_W-1:0]  k_wa;
    logic [31:0]       ax_wd, fz_wd, sl_wd;

    always_comb begin
        ax_wen = clr_on || ax_we;
        fz_wen = clr_on || fz_we;
        sl_wen = clr_on ? (r_clr < CLR_W'(SDEP)) : sl_we;
        kd_wen = clr_on || kd_we;
        kc_wen = clr_on || kc_we;
        ax_wa  = clr_on ? AXIS_W'(r_clr) : AXIS_W'(c);
        sl_wa  = clr_on ? SDEP_W'(r_clr)
                        : SDEP_W'(r_slot) * SDEP_W'(SLOT_AXES) + SDEP_W'(c - MT_FIRST);
        k_wa   = clr_on ? KEY_W'(r_clr) : kidx;
        ax_wd  = clr_on ? 32'd0 : nv;
        fz_wd  = clr_on ? 32'd0 : v;
        sl_wd  = clr_on ? 32'd0 : nv;
        kd_wd  = !clr_on && (v != 32'd0);
        kc_wd  = !clr_on && v[0];
    end

    iefa_ram #(.WIDTH(32), .DEPTH(AXIS_COUNT)) u_axis (
        .i_clk(i_clk), .i_we(ax_wen), .i_waddr(ax_wa), .i_wdata(ax_wd),
        .i_raddr(a_addr), .o_rdata(a_rd));
    iefa_ram #(.WIDTH(32), .DEPTH(AXIS_COUNT)) u_fuzz (
        .i_clk(i_clk), .i_we(fz_wen), .i_waddr(ax_wa), .i_wdata(fz_wd),
        .i_raddr(a_addr), .o_rdata(f_rd));
    iefa_ram #(.WIDTH(32), .DEPTH(SDEP)) u_slot (
        .i_clk(i_clk), .i_we(sl_wen), .i_waddr(sl_wa),
        .i_wdata(sl_wd), .i_raddr(s_addr), .o_rdata(s_rd));
    iefa_ram #(.WIDTH(1), .DEPTH(KEY_COUNT)) u_kdown (
        .i_clk(i_clk), .i_we(kd_wen), .i_waddr(k_wa), .i_wdata(kd_wd),
        .i_raddr(ridx), .o_rdata(kd_rd));
    iefa_ram #(.WIDTH(1), .DEPTH(KEY_COUNT)) u_kcap (
        .i_clk(i_clk), .i_we(kc_wen), .i_waddr(k_wa), .i_wdata(kc_wd),
        .i_raddr(ridx), .o_rdata(kc_rd));

    assign o_empty = (r_ocnt == 3'd0);
    assign o_res   = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_pub <= '0; r_slot <= '0;
            r_rcode <= '0; r_armed <= 1'b0; r_cnt <= '0;
            r_owp <= '0; r_orp <= '0; r_ocnt <= '0;
            r_clr <= '0;
        end else begin
            r_busy <= go;
            r_pub <= pub_w; r_slot <= n_slot;
            r_rcode <= n_rcode; r_armed <= n_armed; r_cnt <= n_cnt;
            if (clr_on) r_clr <= r_clr + 1'b1;
            if (nres != 2'd0) r_oq[r_owp] <= e0;
            if (nres == 2'd2) r_oq[r_owp + 2'd1] <= e1;
            r_owp  <= r_owp + nres;
            r_orp  <= r_orp + 2'((i_pop && !o_empty) ? 1 : 0);
            r_ocnt <= r_ocnt + 3'(nres) - 3'((i_pop && !o_empty) ? 1 : 0);
        end
        if (go) r_c <= i_cmd;
    end
endmodule
